// ===== sv/pie_pkg.sv =====
// ============================================================================
// pie_pkg - shared definitions for the proximity index evaluator
// Widths, command and register codes, and the shared adder request/response.
// ============================================================================
package pie_pkg;

    // field and state widths
    localparam int unsigned CMD_W      = 2;
    localparam int unsigned SAMPLE_W   = 16;
    localparam int unsigned GAIN_W     = 16;
    localparam int unsigned SUM_W      = 32;
    localparam int unsigned COUNT_W    = 16;
    localparam int unsigned PEAK_SUM_W = 24;
    localparam int unsigned INDEX_W    = 40;
    localparam int unsigned MISS_W     = 3;
    localparam int unsigned CFG_IDX_W  = 2;

    // shared adder width: covers the widest product (16 x 24 x 16 bits)
    localparam int unsigned ALU_W      = 56;

    // sample store limit default
    localparam int unsigned MAX_SAMPLES_DEF = 65535;

    // the best is halved on a miss once the miss count is above this limit
    localparam logic [MISS_W-1:0] MISS_LIMIT = 3'd3;

    // configuration reset values
    localparam logic [GAIN_W-1:0] GAIN_MEAN_RST    = 16'd128;
    localparam logic [GAIN_W-1:0] GAIN_PEAKS_RST   = 16'd256;
    localparam logic [GAIN_W-1:0] INTERVAL_LEN_RST = 16'd128;

    // input commands
    typedef enum logic [CMD_W-1:0] {
        CMD_SAMPLE = 2'd0,
        CMD_MARK   = 2'd1,
        CMD_EVAL   = 2'd2
    } cmd_t;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GAIN_MEAN    = 2'd0,
        REG_GAIN_PEAKS   = 2'd1,
        REG_INTERVAL_LEN = 2'd2
    } cfg_reg_t;

    // shared adder request and response
    typedef struct packed {
        logic [ALU_W-1:0] a;
        logic [ALU_W-1:0] b;
        logic             sub;
    } alu_req_t;

    typedef struct packed {
        logic [ALU_W-1:0] sum;
        logic             carry;
    } alu_rsp_t;

endpackage

// ===== sv/pie_addsub.sv =====
// ============================================================================
// pie_addsub - shared add/subtract unit
// One wide adder used for divider trial subtracts, shift-add multiply steps,
// the final sum and the best-index compare. carry high on a subtract means
// no borrow (a >= b).
// ============================================================================
module pie_addsub (
    input  pie_pkg::alu_req_t req,
    output pie_pkg::alu_rsp_t rsp
);
    import pie_pkg::*;

    logic [ALU_W:0]   full;
    logic [ALU_W-1:0] b_eff;

    // invert and add one for subtract
    assign b_eff = req.sub ? ~req.b : req.b;
    assign full  = {1'b0, req.a} + {1'b0, b_eff} + {{ALU_W{1'b0}}, req.sub};

    assign rsp.sum   = full[ALU_W-1:0];
    assign rsp.carry = full[ALU_W];

endmodule

// ===== sv/proximity_index_evaluator.sv =====
// ============================================================================
// proximity_index_evaluator - gas proximity index with best tracking
// Accumulates samples and interval maxima; on evaluate forms
// gain_mean*avg + (gain_peaks*peak_sum*interval_len)>>8, saturates it,
// updates the stored best and miss count and emits one result.
// ============================================================================
//
//  channel  | signals                                   | transaction
//  ---------+-------------------------------------------+----------------------
//  input    | in_valid, in_ready, command, sample       | one command
//  output   | out_valid, out_ready, proximity,          | one evaluate result
//           | new_spiral, best_after, misses_after      |
//  config   | cfg_we, cfg_index, cfg_wdata              | one register write
//
//  Sample, interval mark and unused commands are taken straight from idle.
//  Evaluate runs 32 divide steps (skipped without samples), 3 x 16 multiply
//  steps, then add, compare and finish, all on the one shared adder; in_ready
//  is low meanwhile.
//  The finished result sits in an output register, so samples are taken while
//  it waits; a second evaluate holds in its finish step until that is taken.
//  rst_n clears control and accumulator state and loads the reset values.
// ============================================================================
module proximity_index_evaluator #(
    parameter int unsigned MAX_SAMPLES = pie_pkg::MAX_SAMPLES_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // input channel
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [pie_pkg::CMD_W-1:0]      command,
    input  logic [pie_pkg::SAMPLE_W-1:0]   sample,
    // output channel
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [pie_pkg::INDEX_W-1:0]    proximity,
    output logic                           new_spiral,
    output logic [pie_pkg::INDEX_W-1:0]    best_after,
    output logic [pie_pkg::MISS_W-1:0]     misses_after,
    // configuration
    input  logic                           cfg_we,
    input  logic [pie_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [pie_pkg::GAIN_W-1:0]     cfg_wdata
);
    import pie_pkg::*;

    localparam logic [COUNT_W-1:0] MAX_CNT  = COUNT_W'(MAX_SAMPLES);
    localparam int unsigned        STEP_W   = 5;
    localparam logic [STEP_W-1:0]  DIV_LAST = STEP_W'(SUM_W - 1);
    localparam logic [STEP_W-1:0]  MUL_LAST = STEP_W'(GAIN_W - 1);
    localparam int unsigned        REM_W    = COUNT_W + 1;
    localparam int unsigned        FRAC_SH  = 8;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_MUL_MEAN,
        ST_MUL_PEAK,
        ST_MUL_LEN,
        ST_ADD,
        ST_CMP,
        ST_FIN
    } state_t;

    state_t                 state_reg, state_next;

    // configuration
    logic [GAIN_W-1:0]      gain_mean_reg, gain_mean_next;
    logic [GAIN_W-1:0]      gain_peaks_reg, gain_peaks_next;
    logic [GAIN_W-1:0]      interval_len_reg, interval_len_next;

    // accumulators
    logic [SUM_W-1:0]       sum_reg, sum_next;
    logic [COUNT_W-1:0]     count_reg, count_next;
    logic [SAMPLE_W-1:0]    peak_reg, peak_next;
    logic                   seen_reg, seen_next;
    logic [PEAK_SUM_W-1:0]  peak_sum_reg, peak_sum_next;
    logic [INDEX_W-1:0]     best_reg, best_next;
    logic [MISS_W-1:0]      miss_reg, miss_next;

    // sequencer working registers
    logic [STEP_W-1:0]      step_reg, step_next;
    logic [COUNT_W-1:0]     rem_reg, rem_next;
    logic [SUM_W-1:0]       quo_reg, quo_next;
    logic [ALU_W-1:0]       acc_reg, acc_next;
    logic [ALU_W-1:0]       mcand_reg, mcand_next;
    logic [GAIN_W-1:0]      mplier_reg, mplier_next;
    logic [SUM_W-1:0]       mean_reg, mean_next;
    logic [INDEX_W-1:0]     pi_reg, pi_next;
    logic                   spiral_reg, spiral_next;

    // output register
    logic                   out_valid_reg, out_valid_next;
    logic [INDEX_W-1:0]     proximity_reg, proximity_next;
    logic                   new_spiral_reg, new_spiral_next;
    logic [INDEX_W-1:0]     best_after_reg, best_after_next;
    logic [MISS_W-1:0]      misses_after_reg, misses_after_next;

    // shared unit and helpers
    alu_req_t               alu_req;
    alu_rsp_t               alu_rsp;
    logic [REM_W-1:0]       div_shift;
    logic [PEAK_SUM_W:0]    peak_sum_add;
    logic [PEAK_SUM_W-1:0]  peak_sum_closed;

    pie_addsub u_addsub (
        .req (alu_req),
        .rsp (alu_rsp)
    );

    // closing the current interval adds its maximum, saturating
    assign peak_sum_add    = {1'b0, peak_sum_reg} + {{(PEAK_SUM_W+1-SAMPLE_W){1'b0}}, peak_reg};
    assign peak_sum_closed = !seen_reg ? peak_sum_reg :
                             (peak_sum_add[PEAK_SUM_W] ? '1 : peak_sum_add[PEAK_SUM_W-1:0]);

    // next partial remainder candidate for the divider
    assign div_shift = {rem_reg, quo_reg[SUM_W-1]};

    assign in_ready = (state_reg == ST_IDLE);

    // sequencer and datapath next state
    always_comb
    begin
        state_next        = state_reg;
        gain_mean_next    = gain_mean_reg;
        gain_peaks_next   = gain_peaks_reg;
        interval_len_next = interval_len_reg;
        sum_next          = sum_reg;
        count_next        = count_reg;
        peak_next         = peak_reg;
        seen_next         = seen_reg;
        peak_sum_next     = peak_sum_reg;
        best_next         = best_reg;
        miss_next         = miss_reg;
        step_next         = step_reg;
        rem_next          = rem_reg;
        quo_next          = quo_reg;
        acc_next          = acc_reg;
        mcand_next        = mcand_reg;
        mplier_next       = mplier_reg;
        mean_next         = mean_reg;
        pi_next           = pi_reg;
        spiral_next       = spiral_reg;
        out_valid_next    = out_valid_reg && !out_ready;
        proximity_next    = proximity_reg;
        new_spiral_next   = new_spiral_reg;
        best_after_next   = best_after_reg;
        misses_after_next = misses_after_reg;
        alu_req           = '0;

        // configuration writes
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_GAIN_MEAN:    gain_mean_next    = cfg_wdata;
                REG_GAIN_PEAKS:   gain_peaks_next   = cfg_wdata;
                REG_INTERVAL_LEN: interval_len_next = cfg_wdata;
                default:          ;
            endcase
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    case (command)
                        CMD_SAMPLE:
                        begin
                            // ignored once the sample store is full
                            if (count_reg < MAX_CNT)
                            begin
                                sum_next   = sum_reg + SUM_W'(sample);
                                count_next = count_reg + 1'b1;
                                if (!seen_reg || sample > peak_reg)
                                begin
                                    peak_next = sample;
                                end
                                seen_next = 1'b1;
                            end
                        end
                        CMD_MARK:
                        begin
                            peak_sum_next = peak_sum_closed;
                            peak_next     = '0;
                            seen_next     = 1'b0;
                        end
                        CMD_EVAL:
                        begin
                            peak_sum_next = peak_sum_closed;
                            peak_next     = '0;
                            seen_next     = 1'b0;
                            if (count_reg == '0)
                            begin
                                // no samples: average taken as zero
                                acc_next    = '0;
                                mcand_next  = ALU_W'(gain_mean_reg);
                                mplier_next = '0;
                                step_next   = MUL_LAST;
                                state_next  = ST_MUL_MEAN;
                            end
                            else
                            begin
                                rem_next   = '0;
                                quo_next   = sum_reg;
                                step_next  = DIV_LAST;
                                state_next = ST_DIV;
                            end
                        end
                        default: ;
                    endcase
                end
            end

            // restoring divide, one quotient bit a cycle
            ST_DIV:
            begin
                alu_req.a   = ALU_W'(div_shift);
                alu_req.b   = ALU_W'(count_reg);
                alu_req.sub = 1'b1;
                rem_next    = alu_rsp.carry ? alu_rsp.sum[COUNT_W-1:0] :
                              div_shift[COUNT_W-1:0];
                quo_next    = {quo_reg[SUM_W-2:0], alu_rsp.carry};
                step_next   = step_reg - 1'b1;
                if (step_reg == '0)
                begin
                    acc_next    = '0;
                    mcand_next  = ALU_W'(gain_mean_reg);
                    mplier_next = quo_next[GAIN_W-1:0];
                    step_next   = MUL_LAST;
                    state_next  = ST_MUL_MEAN;
                end
            end

            // shift-add multiply steps
            ST_MUL_MEAN, ST_MUL_PEAK, ST_MUL_LEN:
            begin
                alu_req.a   = acc_reg;
                alu_req.b   = mplier_reg[0] ? mcand_reg : '0;
                alu_req.sub = 1'b0;
                acc_next    = alu_rsp.sum;
                mcand_next  = mcand_reg << 1;
                mplier_next = mplier_reg >> 1;
                step_next   = step_reg - 1'b1;
                if (step_reg == '0)
                begin
                    step_next = MUL_LAST;
                    acc_next  = '0;
                    if (state_reg == ST_MUL_MEAN)
                    begin
                        mean_next   = alu_rsp.sum[SUM_W-1:0];
                        mcand_next  = ALU_W'(peak_sum_reg);
                        mplier_next = gain_peaks_reg;
                        state_next  = ST_MUL_PEAK;
                    end
                    else if (state_reg == ST_MUL_PEAK)
                    begin
                        mcand_next  = ALU_W'(alu_rsp.sum[INDEX_W-1:0]);
                        mplier_next = interval_len_reg;
                        state_next  = ST_MUL_LEN;
                    end
                    else
                    begin
                        acc_next   = alu_rsp.sum;
                        state_next = ST_ADD;
                    end
                end
            end

            // mean term plus truncated peak term, saturated
            ST_ADD:
            begin
                alu_req.a   = acc_reg >> FRAC_SH;
                alu_req.b   = ALU_W'(mean_reg);
                alu_req.sub = 1'b0;
                pi_next     = (|alu_rsp.sum[ALU_W-1:INDEX_W]) ? '1 :
                              alu_rsp.sum[INDEX_W-1:0];
                state_next  = ST_CMP;
            end

            // borrow on best - index means the index is greater
            ST_CMP:
            begin
                alu_req.a   = ALU_W'(best_reg);
                alu_req.b   = ALU_W'(pi_reg);
                alu_req.sub = 1'b1;
                spiral_next = !alu_rsp.carry;
                state_next  = ST_FIN;
            end

            // update best and misses, hand over the result, clear accumulators
            ST_FIN:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    if (spiral_reg)
                    begin
                        best_next = pi_reg;
                        miss_next = '0;
                    end
                    else if (miss_reg > MISS_LIMIT)
                    begin
                        best_next = best_reg >> 1;
                        miss_next = '0;
                    end
                    else
                    begin
                        miss_next = miss_reg + 1'b1;
                    end
                    out_valid_next    = 1'b1;
                    proximity_next    = pi_reg;
                    new_spiral_next   = spiral_reg;
                    best_after_next   = best_next;
                    misses_after_next = miss_next;
                    sum_next          = '0;
                    count_next        = '0;
                    peak_next         = '0;
                    seen_next         = 1'b0;
                    peak_sum_next     = '0;
                    state_next        = ST_IDLE;
                end
            end

            default: state_next = ST_IDLE;
        endcase
    end

    // state and registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            gain_mean_reg    <= GAIN_MEAN_RST;
            gain_peaks_reg   <= GAIN_PEAKS_RST;
            interval_len_reg <= INTERVAL_LEN_RST;
            sum_reg          <= '0;
            count_reg        <= '0;
            peak_reg         <= '0;
            seen_reg         <= 1'b0;
            peak_sum_reg     <= '0;
            best_reg         <= '0;
            miss_reg         <= '0;
            step_reg         <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            gain_mean_reg    <= gain_mean_next;
            gain_peaks_reg   <= gain_peaks_next;
            interval_len_reg <= interval_len_next;
            sum_reg          <= sum_next;
            count_reg        <= count_next;
            peak_reg         <= peak_next;
            seen_reg         <= seen_next;
            peak_sum_reg     <= peak_sum_next;
            best_reg         <= best_next;
            miss_reg         <= miss_next;
            step_reg         <= step_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        rem_reg          <= rem_next;
        quo_reg          <= quo_next;
        acc_reg          <= acc_next;
        mcand_reg        <= mcand_next;
        mplier_reg       <= mplier_next;
        mean_reg         <= mean_next;
        pi_reg           <= pi_next;
        spiral_reg       <= spiral_next;
        proximity_reg    <= proximity_next;
        new_spiral_reg   <= new_spiral_next;
        best_after_reg   <= best_after_next;
        misses_after_reg <= misses_after_next;
    end

    assign out_valid    = out_valid_reg;
    assign proximity    = proximity_reg;
    assign new_spiral   = new_spiral_reg;
    assign best_after   = best_after_reg;
    assign misses_after = misses_after_reg;

`ifndef SYNTH
    // a result only appears out of the finish step
    a_result_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg == ST_FIN))
        else $error("result raised outside finish step");

    // a new spiral makes the index the stored best
    a_spiral_best: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && new_spiral) |-> (best_after == proximity))
        else $error("new spiral without best update");

    // miss count never passes the halving point
    a_miss_bound: assert property (@(posedge clk) disable iff (!rst_n)
        miss_reg <= (MISS_LIMIT + 3'd1))
        else $error("miss count out of range");

    // sample count stays within the store
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= MAX_CNT)
        else $error("sample count beyond store size");
`endif

endmodule
